@@ src/apic_pkg.sv @@
`timescale 1ns / 1ps

package apic_pkg;

    localparam int COUNT_BITS_DEF = 32;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // Register offsets, byte offset divided by 16
    localparam logic [5:0] IDX_EOI        = 6'h0B;
    localparam logic [5:0] IDX_SPURIOUS   = 6'h0F;
    localparam logic [5:0] IDX_LVT_TIMER  = 6'h32;
    localparam logic [5:0] IDX_INIT_COUNT = 6'h38;
    localparam logic [5:0] IDX_CURR_COUNT = 6'h39;
    localparam logic [5:0] IDX_DIVIDE     = 6'h3E;

    localparam int LVT_MASK_POS  = 16;
    localparam int LVT_MODE_POS  = 17;
    localparam int SW_ENABLE_POS = 8;

    localparam logic [1:0] TMODE_ONESHOT  = 2'd0;
    localparam logic [1:0] TMODE_PERIODIC = 2'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  reg_index;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0]  irq_vector;
        logic        irq_fire;
        logic [31:0] read_data;
    } result_t;

    // {b3,b1,b0} selects 2^(v+1); 111 means divide by one
    function automatic logic [7:0] divide_ratio(input logic [3:0] code);
        logic [2:0] v;
        begin
            v = {code[3], code[1:0]};
            if (v == 3'd7) begin
                divide_ratio = 8'd1;
            end else begin
                divide_ratio = 8'd2 << v;
            end
        end
    endfunction

endpackage

@@ src/apic_tmr_core.sv @@
`timescale 1ns / 1ps

module apic_tmr_core #(
    parameter int COUNT_BITS = apic_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    input  apic_pkg::req_t    req,
    output apic_pkg::result_t result
);
    import apic_pkg::*;

    logic [7:0]            tmr_vector_reg,   tmr_vector_next;
    logic                  tmr_masked_reg,   tmr_masked_next;
    logic [1:0]            tmr_mode_reg,     tmr_mode_next;
    logic [COUNT_BITS-1:0] load_count_reg,   load_count_next;
    logic [COUNT_BITS-1:0] curr_count_reg,   curr_count_next;
    logic [3:0]            divide_code_reg,  divide_code_next;
    logic [6:0]            prescale_reg,     prescale_next;
    logic [8:0]            spurious_reg,     spurious_next;

    logic [COUNT_BITS-1:0] count_dec;
    logic [7:0]            presc_inc;

    assign count_dec = curr_count_reg - 1'b1;
    assign presc_inc = {1'b0, prescale_reg} + 8'd1;

    always_comb begin
        tmr_vector_next  = tmr_vector_reg;
        tmr_masked_next  = tmr_masked_reg;
        tmr_mode_next    = tmr_mode_reg;
        load_count_next  = load_count_reg;
        curr_count_next  = curr_count_reg;
        divide_code_next = divide_code_reg;
        prescale_next    = prescale_reg;
        spurious_next    = spurious_reg;
        result           = '0;

        if (req_valid) begin
            case (req.op)
                OP_TICK: begin
                    // modes 2 and 3 keep the timer stopped
                    if (curr_count_reg != '0 && !tmr_mode_reg[1]) begin
                        if (presc_inc >= divide_ratio(divide_code_reg)) begin
                            prescale_next   = '0;
                            curr_count_next = count_dec;
                            if (count_dec == '0) begin
                                if (!tmr_masked_reg && spurious_reg[SW_ENABLE_POS]) begin
                                    result.irq_fire   = 1'b1;
                                    result.irq_vector = tmr_vector_reg;
                                end
                                if (tmr_mode_reg == TMODE_PERIODIC) begin
                                    curr_count_next = load_count_reg;
                                end
                            end
                        end else begin
                            prescale_next = presc_inc[6:0];
                        end
                    end
                end
                OP_READ: begin
                    case (req.reg_index)
                        IDX_SPURIOUS:   result.read_data = {23'd0, spurious_reg};
                        IDX_LVT_TIMER:  result.read_data = {13'd0, tmr_mode_reg,
                                                            tmr_masked_reg, 8'd0,
                                                            tmr_vector_reg};
                        IDX_INIT_COUNT: result.read_data = 32'(load_count_reg);
                        IDX_CURR_COUNT: result.read_data = 32'(curr_count_reg);
                        IDX_DIVIDE:     result.read_data = {28'd0, divide_code_reg};
                        default:        result.read_data = '0;
                    endcase
                end
                OP_WRITE: begin
                    case (req.reg_index)
                        IDX_SPURIOUS: spurious_next = req.write_data[8:0];
                        IDX_LVT_TIMER: begin
                            tmr_vector_next = req.write_data[7:0];
                            tmr_masked_next = req.write_data[LVT_MASK_POS];
                            tmr_mode_next   = req.write_data[LVT_MODE_POS +: 2];
                        end
                        IDX_INIT_COUNT: begin
                            load_count_next = req.write_data[COUNT_BITS-1:0];
                            curr_count_next = req.write_data[COUNT_BITS-1:0];
                            prescale_next   = '0;
                        end
                        IDX_DIVIDE: divide_code_next = {req.write_data[3], 1'b0,
                                                        req.write_data[1:0]};
                        default: ; // EOI, current count and unlisted offsets
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmr_vector_reg  <= '0;
            tmr_masked_reg  <= 1'b1;
            tmr_mode_reg    <= TMODE_ONESHOT;
            load_count_reg  <= '0;
            curr_count_reg  <= '0;
            divide_code_reg <= '0;
            prescale_reg    <= '0;
            spurious_reg    <= 9'h0FF;
        end else begin
            tmr_vector_reg  <= tmr_vector_next;
            tmr_masked_reg  <= tmr_masked_next;
            tmr_mode_reg    <= tmr_mode_next;
            load_count_reg  <= load_count_next;
            curr_count_reg  <= curr_count_next;
            divide_code_reg <= divide_code_next;
            prescale_reg    <= prescale_next;
            spurious_reg    <= spurious_next;
        end
    end

`ifndef SYNTH
    a_fire_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        result.irq_fire |-> (!tmr_masked_reg && spurious_reg[SW_ENABLE_POS]))
        else $error("interrupt raised while masked or software-disabled");

    a_stopped_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req.op == OP_TICK && tmr_mode_reg[1])
        |=> $stable(curr_count_reg))
        else $error("count moved in a stopped timer mode");

    a_oneshot_expires: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.irq_fire && tmr_mode_reg == TMODE_ONESHOT)
        |=> curr_count_reg == '0)
        else $error("one-shot timer did not stop on expiry");

    a_tick_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req.op != OP_READ) |-> result.read_data == '0)
        else $error("read data on a non-read transaction");
`endif

endmodule

@@ src/apic_countdown_timer.sv @@
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                          tuser
// s_       in   reg_index[5:0], write_data[37:6]            mode[1:0]
// m_       out  read_data[31:0], irq_fire[32], vector[40:33] -
//
// One transaction per cycle in and out while the m_ side is not stalled; a result appears in the
// cycle after its transaction is accepted, from the output register.
// Timer state updates on the accepting edge; the only loop is the
// count/prescaler update, a single pass of decrement and compare.
// aresetn is synchronous: timer masked, count stopped, software disabled.
// A stalled m_ side stalls s_ only while the output register is full.

module apic_countdown_timer #(
    parameter int COUNT_BITS = apic_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [apic_pkg::S_TDATA_W-1:0] s_tdata,  // reg_index, write_data, 2'b0 pad
    input  logic [apic_pkg::S_TUSER_W-1:0] s_tuser,  // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [apic_pkg::M_TDATA_W-1:0] m_tdata   // read_data, irq_fire, irq_vector, pad
);
    import apic_pkg::*;

    logic    accept;
    req_t    req;
    result_t result;

    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_res_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign req.op         = op_t'(s_tuser);
    assign req.reg_index  = s_tdata[5:0];
    assign req.write_data = s_tdata[37:6];

    apic_tmr_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (accept),
        .req       (req),
        .result    (result)
    );

    always_comb begin
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_res_reg};

`ifndef SYNTH
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted transaction left no result");

    a_vector_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_res_reg.irq_fire) |-> m_res_reg.irq_vector == '0)
        else $error("vector present without interrupt");

    a_irq_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req.op != OP_TICK) |=> !m_res_reg.irq_fire)
        else $error("interrupt on a register access");
`endif

endmodule

@@ dv/apic_countdown_timer_test.sv @@
`timescale 1ns / 1ps

module apic_countdown_timer_test;
    import apic_pkg::*;

    localparam int CNT_W       = COUNT_BITS_DEF;
    localparam int RESET_CYC   = 7;
    localparam int CHUNK       = 50;
    localparam int RANDOM_N    = 1900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // idling profiles, one per stretch of stimulus
    localparam int PH_FLAT   = 0;
    localparam int PH_SRC    = 1;
    localparam int PH_SINK   = 2;
    localparam int PH_BOTH   = 3;

    typedef struct {
        op_t         op;
        logic [5:0]  idx;
        logic [31:0] data;
        int          phase;
    } access_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // reg_index, write_data, pad
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // read_data, irq_fire, irq_vector, pad

    access_t pending_accesses[$];
    result_t expected_results[$];
    int      accepted_count = 0;
    int      issued_count   = 0;
    int      live_phase     = PH_FLAT;
    int      mismatches     = 0;
    int      cycles         = 0;

    // timer state as predicted
    logic [7:0]  lvt_vector;
    logic        lvt_masked;
    logic [1:0]  lvt_mode;
    logic [31:0] load_count;
    logic [31:0] curr_count;
    logic [3:0]  div_code;
    logic [6:0]  prescale;
    logic [8:0]  spurious;

    apic_countdown_timer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic clear_timer();
        lvt_vector = 8'd0;
        lvt_masked = 1'b1;
        lvt_mode   = TMODE_ONESHOT;
        load_count = 32'd0;
        curr_count = 32'd0;
        div_code   = 4'd0;
        prescale   = 7'd0;
        spurious   = 9'h0FF;
    endtask

    task automatic step_timer(input op_t op, input logic [5:0] idx, input logic [31:0] data,
                              output result_t res);
        logic [2:0] sel;
        logic [7:0] ratio;
        res = '0;
        case (op)
            OP_TICK: begin
                if (curr_count != 0 && lvt_mode <= TMODE_PERIODIC) begin
                    sel   = {div_code[3], div_code[1:0]};
                    ratio = (sel == 3'd7) ? 8'd1 : 8'(9'd1 << (sel + 3'd1));
                    // prescaler may already sit past a freshly shortened ratio
                    if (8'(prescale) + 8'd1 >= ratio) begin
                        prescale   = 7'd0;
                        curr_count = curr_count - 32'd1;
                        if (curr_count == 0) begin
                            if (!lvt_masked && spurious[SW_ENABLE_POS]) begin
                                res.irq_fire   = 1'b1;
                                res.irq_vector = lvt_vector;
                            end
                            if (lvt_mode == TMODE_PERIODIC) curr_count = load_count;
                        end
                    end else begin
                        prescale = prescale + 7'd1;
                    end
                end
            end
            OP_READ: begin
                case (idx)
                    IDX_SPURIOUS:   res.read_data = {23'd0, spurious};
                    IDX_LVT_TIMER:  res.read_data = {13'd0, lvt_mode, lvt_masked, 8'd0,
                                                     lvt_vector};
                    IDX_INIT_COUNT: res.read_data = load_count;
                    IDX_CURR_COUNT: res.read_data = curr_count;
                    IDX_DIVIDE:     res.read_data = {28'd0, div_code};
                    default:        res.read_data = 32'd0;
                endcase
            end
            OP_WRITE: begin
                case (idx)
                    IDX_SPURIOUS: spurious = data[8:0];
                    IDX_LVT_TIMER: begin
                        lvt_vector = data[7:0];
                        lvt_masked = data[LVT_MASK_POS];
                        lvt_mode   = data[LVT_MODE_POS +: 2];
                    end
                    IDX_INIT_COUNT: begin
                        load_count = 32'(data[CNT_W-1:0]);
                        curr_count = load_count;
                        prescale   = 7'd0;
                    end
                    IDX_DIVIDE: div_code = data[3:0] & 4'hB;
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic add_access(input op_t op, input logic [5:0] idx, input logic [31:0] data,
                              input int phase);
        access_t a;
        a.op    = op;
        a.idx   = idx;
        a.data  = data;
        a.phase = phase;
        pending_accesses.push_back(a);
    endtask

    function automatic logic [5:0] known_index();
        case ($urandom_range(5))
            0: return IDX_EOI;
            1: return IDX_SPURIOUS;
            2: return IDX_LVT_TIMER;
            3: return IDX_INIT_COUNT;
            4: return IDX_CURR_COUNT;
            default: return IDX_DIVIDE;
        endcase
    endfunction

    // mostly ticks with short counts and fast dividers, so the timer keeps expiring
    task automatic add_random_access(input int phase);
        int          pick;
        op_t         op;
        logic [5:0]  idx;
        logic [31:0] data;
        pick = $urandom_range(99);
        idx  = 6'($urandom_range(63));
        data = $urandom;
        if (pick < 55) begin
            op = OP_TICK;
        end else if (pick < 72) begin
            op = OP_READ;
            if ($urandom_range(9) != 0) idx = known_index();
        end else if (pick < 95) begin
            op = OP_WRITE;
            if ($urandom_range(9) != 0) idx = known_index();
            case (idx)
                IDX_INIT_COUNT: begin
                    pick = $urandom_range(9);
                    if (pick < 8) data = 32'($urandom_range(12, 1));
                    else if (pick == 8) data = 32'd0;
                end
                IDX_LVT_TIMER: begin
                    data[LVT_MASK_POS] = ($urandom_range(3) == 0);
                    if ($urandom_range(9) != 0) data[LVT_MODE_POS +: 2] = 2'($urandom_range(1));
                end
                IDX_DIVIDE: begin
                    pick = $urandom_range(3);
                    if (pick == 0) data[3:0] = 4'hB;
                    else if (pick == 1) data[3:0] = 4'h0;
                end
                IDX_SPURIOUS: data[SW_ENABLE_POS] = ($urandom_range(4) != 0);
                default: ;
            endcase
        end else begin
            op = OP_NOP;
        end
        add_access(op, idx, data, phase);
    endtask

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0s at cycle %0d: read_data exp %h got %h, irq_fire exp %b got %b, %0s %h %0s %h",
                     what, cycles, want.read_data, got.read_data, want.irq_fire, got.irq_fire,
                     "irq_vector exp", want.irq_vector, "got", got.irq_vector);
        end
    endtask

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // driver: falling edge
    always @(negedge aclk) begin
        access_t nxt;
        bit      src_idle;
        bit      sink_stall;
        if (aresetn) begin
            if (!s_tvalid || accepted_count == issued_count) begin
                src_idle = 1'b0;
                if (pending_accesses.size() != 0) begin
                    live_phase = pending_accesses[0].phase;
                    if (live_phase == PH_SRC) src_idle = roll(66);
                    else if (live_phase == PH_BOTH) src_idle = roll(33);
                end
                if (pending_accesses.size() != 0 && !src_idle) begin
                    nxt = pending_accesses.pop_front();
                    s_tdata      <= {2'b00, nxt.data, nxt.idx};
                    s_tuser      <= nxt.op;
                    s_tvalid     <= 1'b1;
                    issued_count <= issued_count + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            sink_stall = 1'b0;
            if (live_phase == PH_SINK) sink_stall = roll(66);
            else if (live_phase == PH_BOTH) sink_stall = roll(33);
            m_tready <= !sink_stall;
        end
    end

    // monitor: rising edge
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            clear_timer();
        end else begin
            if (s_tvalid && s_tready) begin
                step_timer(op_t'(s_tuser), s_tdata[5:0], s_tdata[37:6], want);
                expected_results.push_back(want);
                accepted_count <= accepted_count + 1;
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[40:0]);
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected transaction", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data || got.irq_fire !== want.irq_fire ||
                        got.irq_vector !== want.irq_vector) begin
                        note_mismatch("mismatch", want, got);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        // state straight out of reset, then unused bits and odd offsets
        add_access(OP_READ,  IDX_SPURIOUS,   32'd0,        PH_FLAT);
        add_access(OP_READ,  IDX_LVT_TIMER,  32'd0,        PH_FLAT);
        add_access(OP_READ,  6'h3F,          32'hFFFFFFFF, PH_FLAT);
        add_access(OP_NOP,   6'h3F,          32'hFFFFFFFF, PH_FLAT);
        add_access(OP_WRITE, IDX_SPURIOUS,   32'hFFFFFFFF, PH_FLAT);
        add_access(OP_WRITE, IDX_LVT_TIMER,  32'hFFFFFFFF, PH_FLAT);
        add_access(OP_WRITE, IDX_DIVIDE,     32'hFFFFFFFF, PH_FLAT);
        add_access(OP_READ,  IDX_DIVIDE,     32'd0,        PH_FLAT);
        // reserved timer mode: counts load but never run
        add_access(OP_WRITE, IDX_INIT_COUNT, 32'hFFFFFFFF, PH_FLAT);
        add_access(OP_TICK,  6'h00,          32'd0,        PH_FLAT);
        add_access(OP_WRITE, IDX_CURR_COUNT, 32'h00001234, PH_FLAT);
        add_access(OP_WRITE, IDX_EOI,        32'hFFFFFFFF, PH_FLAT);
        add_access(OP_WRITE, 6'h00,          32'hFFFFFFFF, PH_FLAT);
        add_access(OP_READ,  IDX_CURR_COUNT, 32'd0,        PH_FLAT);
        // periodic, unmasked, divide by one: fires on the second tick and reloads
        add_access(OP_WRITE, IDX_LVT_TIMER,  32'h00020041, PH_FLAT);
        add_access(OP_WRITE, IDX_INIT_COUNT, 32'd2,        PH_FLAT);
        repeat (3) add_access(OP_TICK, 6'h3F, 32'hFFFFFFFF, PH_FLAT);
        // masked periodic still expires and reloads, silently
        add_access(OP_WRITE, IDX_LVT_TIMER,  32'h00030043, PH_FLAT);
        add_access(OP_WRITE, IDX_INIT_COUNT, 32'd1,        PH_FLAT);
        add_access(OP_TICK,  6'h00,          32'd0,        PH_FLAT);
        // shorten the divider with the prescaler already past the new ratio
        add_access(OP_WRITE, IDX_LVT_TIMER,  32'h00000042, PH_FLAT);
        add_access(OP_WRITE, IDX_DIVIDE,     32'h0000000A, PH_FLAT);
        add_access(OP_WRITE, IDX_INIT_COUNT, 32'd3,        PH_FLAT);
        repeat (5) add_access(OP_TICK, 6'h00, 32'd0, PH_FLAT);
        add_access(OP_WRITE, IDX_DIVIDE,     32'd0,        PH_FLAT);
        add_access(OP_TICK,  6'h00,          32'd0,        PH_FLAT);
        add_access(OP_READ,  IDX_CURR_COUNT, 32'd0,        PH_FLAT);
        // zero count stops; software disable suppresses delivery
        add_access(OP_WRITE, IDX_INIT_COUNT, 32'd0,        PH_FLAT);
        add_access(OP_TICK,  6'h00,          32'd0,        PH_FLAT);
        add_access(OP_WRITE, IDX_SPURIOUS,   32'h000000FF, PH_FLAT);
        add_access(OP_WRITE, IDX_DIVIDE,     32'h0000000B, PH_FLAT);
        add_access(OP_WRITE, IDX_INIT_COUNT, 32'd1,        PH_FLAT);
        add_access(OP_TICK,  6'h00,          32'd0,        PH_FLAT);

        for (int k = 0; k < RANDOM_N; k++) add_random_access((k / CHUNK) % 4);

        repeat (RESET_CYC) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_accesses.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ apic_countdown_timer.f @@
src/apic_pkg.sv
src/apic_tmr_core.sv
src/apic_countdown_timer.sv
dv/apic_countdown_timer_test.sv
